// ===== rtl/pts_pkg.sv =====
package pts_pkg;

	localparam int NUM_PRIOS_DEF       = 32;
	localparam int NUM_SLOTS_DEF       = 32;
	localparam int NUM_WAIT_QUEUES_DEF = 16;
	localparam int IDLE_SLOT           = 0;
	localparam int MAIN_SLOT           = 1;
	localparam int IDLE_PRIO           = 1;
	localparam logic [4:0] MAIN_PRIO_RESET = 5'd2;

	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_YIELD  = 3'd1;
	localparam logic [2:0] CMD_EXIT   = 3'd2;
	localparam logic [2:0] CMD_BLOCK  = 3'd3;
	localparam logic [2:0] CMD_WAKE   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_PRIO = 2'd1;
	localparam logic [1:0] ST_NO_SLOT  = 2'd2;
	localparam logic [1:0] ST_NO_WAKE  = 2'd3;

	typedef enum logic [1:0] {
		MODE_YIELD,
		MODE_DEAD,
		MODE_BLOCK,
		MODE_SHORT
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_SCHED,
		S_POP_CHK,
		S_POP_WB,
		S_WAKE_RD,
		S_WAKE_WB,
		S_OUT_RD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [4:0]  task_prio;
		logic [31:0] item_value;
		logic [3:0]  queue_index;
		logic [5:0]  wake_count;
		logic        reschedule;
	} in_beat_t;

	typedef struct packed {
		logic        switched;
		logic [4:0]  prev_task;
		logic [4:0]  next_task;
		logic [31:0] next_value;
		logic [5:0]  new_handle;
		logic [1:0]  status;
	} out_beat_t;

endpackage

// ===== rtl/priority_task_scheduler_core.sv =====
// Hardware task scheduler: one result beat per command beat. For a wake,
// each waiter's queue link is read from the registered link memory
// (S_WAKE_RD) before the waiter is moved (S_WAKE_WB), and a reschedule
// adds the run queue pop (S_SCHED, S_POP_CHK, S_POP_WB). A new command is
// taken once the previous one has reached the output register.
module priority_task_scheduler_core #(
	parameter int NUM_PRIOS       = pts_pkg::NUM_PRIOS_DEF,
	parameter int NUM_SLOTS       = pts_pkg::NUM_SLOTS_DEF,
	parameter int NUM_WAIT_QUEUES = pts_pkg::NUM_WAIT_QUEUES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pts_pkg::in_beat_t in_beat,
	output logic              out_valid,
	input  logic              out_ready,
	output pts_pkg::out_beat_t out_beat,
	input  logic              cfg_we,
	input  logic [4:0]        cfg_data
);
	import pts_pkg::*;

	localparam int SW = $clog2(NUM_SLOTS);
	localparam int PW = $clog2(NUM_PRIOS);
	localparam int QW = (NUM_WAIT_QUEUES > 1) ? $clog2(NUM_WAIT_QUEUES) : 1;

	state_t state_q, state_d;
	mode_t  mode_q;

	logic [SW-1:0] cur_q, prev_q;
	logic [NUM_PRIOS-1:0] mask_q;
	logic [SW-1:0] rq_head_q [NUM_PRIOS];
	logic [SW-1:0] rq_tail_q [NUM_PRIOS];
	logic [NUM_PRIOS-1:0] rq_vld_q;
	logic [SW-1:0] wq_head_q [NUM_WAIT_QUEUES];
	logic [SW-1:0] wq_tail_q [NUM_WAIT_QUEUES];
	logic [NUM_WAIT_QUEUES-1:0] wq_vld_q;
	logic [PW-1:0] prio_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] used_q;
	logic [NUM_SLOTS-1:0] val_ok_q;
	logic [SW:0] dead_q;
	logic [PW-1:0] rp_q;

	logic [2:0]  cmd_q;
	logic [4:0]  tprio_q;
	logic [31:0] ival_q;
	logic [3:0]  qi_q;
	logic [5:0]  cnt_q;
	logic        resch_q;
	logic [5:0]  handle_q;
	logic [1:0]  status_q;

	logic        out_valid_q;
	out_beat_t   out_q;
	logic        out_load;

	logic [SW-1:0] link_mem [NUM_SLOTS];
	logic [31:0]   val_mem [NUM_SLOTS];
	logic [SW-1:0] link_rd_q;
	logic [31:0]   val_rd_q;

	logic          link_we;
	logic [SW-1:0] link_wa, link_wd, link_ra;
	logic          val_we;
	logic [SW-1:0] val_wa;

	logic [PW-1:0] top_p, cp, tp, wp;
	logic [SW-1:0] free_s, ws;
	logic          free_ok, bad_prio, q_ok;
	logic [QW-1:0] qs;
	logic [4:0]    main_clamp;

	function automatic logic rp_lt_cp();
		return top_p < cp;
	endfunction

	assign tp = PW'(tprio_q);
	assign qs = QW'(qi_q);
	assign cp = prio_q[cur_q];
	assign bad_prio = 32'(tprio_q) >= NUM_PRIOS;
	assign q_ok = 32'(qi_q) < NUM_WAIT_QUEUES;
	assign ws = wq_head_q[qs];
	assign wp = prio_q[ws];
	assign main_clamp = (32'(cfg_data) >= NUM_PRIOS) ? 5'(NUM_PRIOS - 1) : cfg_data;

	always_comb begin
		top_p = '0;
		for (int p = 0; p < NUM_PRIOS; p++) begin
			if (mask_q[p]) top_p = PW'(p);
		end
	end

	always_comb begin
		free_s = '0;
		free_ok = 1'b0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				free_s = SW'(s);
				free_ok = 1'b1;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_valid) state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_OUT_RD;
				case (cmd_q)
					CMD_YIELD: state_d = S_SCHED;
					CMD_EXIT:  if (mask_q != '0) state_d = S_SCHED;
					CMD_BLOCK: if (q_ok && mask_q != '0) state_d = S_SCHED;
					CMD_WAKE:  if (q_ok && wq_vld_q[qs] && cnt_q != '0) state_d = S_WAKE_RD;
					default:   state_d = S_OUT_RD;
				endcase
			end
			S_SCHED: begin
				if (mode_q == MODE_YIELD && rp_lt_cp()) state_d = S_OUT_RD;
				else state_d = S_POP_CHK;
			end
			S_POP_CHK: state_d = rq_vld_q[rp_q] ? S_POP_WB : S_OUT_RD;
			S_POP_WB:  state_d = S_OUT_RD;
			S_WAKE_RD: state_d = S_WAKE_WB;
			S_WAKE_WB: begin
				if (wq_head_q[qs] != wq_tail_q[qs] && cnt_q != 6'd1) state_d = S_WAKE_RD;
				else if (resch_q) state_d = S_SCHED;
				else state_d = S_OUT_RD;
			end
			S_OUT_RD:  state_d = S_OUT;
			S_OUT:     if (out_load) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		link_ra = rq_head_q[rp_q];
		val_we  = 1'b0;
		val_wa  = ws;
		unique case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_CREATE: begin
						val_wa = free_s;
						if (!bad_prio && free_ok) begin
							val_we  = 1'b1;
							link_we = rq_vld_q[tp];
							link_wa = rq_tail_q[tp];
							link_wd = free_s;
						end
					end
					CMD_BLOCK: begin
						link_we = q_ok && mask_q != '0 && wq_vld_q[qs];
						link_wa = wq_tail_q[qs];
						link_wd = cur_q;
					end
					CMD_WAKE: begin
						link_we = q_ok && wq_vld_q[qs] && cnt_q != '0 && resch_q && rq_vld_q[cp];
						link_wa = cur_q;
						link_wd = rq_head_q[cp];
					end
					default: link_we = 1'b0;
				endcase
			end
			S_SCHED: begin
				link_we = mode_q == MODE_YIELD && !rp_lt_cp() && rq_vld_q[cp];
				link_wa = rq_tail_q[cp];
				link_wd = cur_q;
			end
			S_WAKE_RD: link_ra = ws;
			S_WAKE_WB: begin
				val_we  = 1'b1;
				link_we = rq_vld_q[wp];
				link_wa = ws;
				link_wd = rq_head_q[wp];
			end
			default: link_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[link_ra];
		if (val_we) val_mem[val_wa] <= ival_q;
		val_rd_q <= val_mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= MODE_YIELD;
			cur_q <= SW'(MAIN_SLOT);
			prev_q <= '0;
			mask_q <= NUM_PRIOS'(1) << IDLE_PRIO;
			rq_vld_q <= NUM_PRIOS'(1) << IDLE_PRIO;
			for (int p = 0; p < NUM_PRIOS; p++) begin
				rq_head_q[p] <= SW'(IDLE_SLOT);
				rq_tail_q[p] <= SW'(IDLE_SLOT);
			end
			wq_vld_q <= '0;
			for (int q = 0; q < NUM_WAIT_QUEUES; q++) begin
				wq_head_q[q] <= '0;
				wq_tail_q[q] <= '0;
			end
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (s == IDLE_SLOT) prio_q[s] <= PW'(IDLE_PRIO);
				else if (s == MAIN_SLOT) prio_q[s] <= PW'(MAIN_PRIO_RESET);
				else prio_q[s] <= '0;
			end
			used_q <= (NUM_SLOTS'(1) << IDLE_SLOT) | (NUM_SLOTS'(1) << MAIN_SLOT);
			val_ok_q <= '0;
			dead_q <= '0;
			rp_q <= '0;
			cmd_q <= '0;
			tprio_q <= '0;
			ival_q <= '0;
			qi_q <= '0;
			cnt_q <= '0;
			resch_q <= 1'b0;
			handle_q <= '0;
			status_q <= ST_OK;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (cfg_we && cur_q == SW'(MAIN_SLOT)) prio_q[MAIN_SLOT] <= PW'(main_clamp);
			if (val_we) val_ok_q[val_wa] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_beat.command;
						tprio_q <= in_beat.task_prio;
						ival_q <= in_beat.item_value;
						qi_q <= in_beat.queue_index;
						cnt_q <= in_beat.wake_count;
						resch_q <= in_beat.reschedule;
						prev_q <= cur_q;
						handle_q <= '0;
						status_q <= ST_OK;
					end
				end
				S_EXEC: begin
					case (cmd_q)
						CMD_CREATE: begin
							if (bad_prio) status_q <= ST_BAD_PRIO;
							else if (!free_ok) status_q <= ST_NO_SLOT;
							else begin
								used_q[free_s] <= 1'b1;
								prio_q[free_s] <= tp;
								if (!rq_vld_q[tp]) rq_head_q[tp] <= free_s;
								rq_tail_q[tp] <= free_s;
								rq_vld_q[tp] <= 1'b1;
								mask_q[tp] <= 1'b1;
								handle_q <= 6'(32'(free_s) + 1);
							end
						end
						CMD_YIELD: mode_q <= MODE_YIELD;
						CMD_EXIT:  mode_q <= MODE_DEAD;
						CMD_BLOCK: begin
							mode_q <= MODE_BLOCK;
							if (q_ok && mask_q != '0) begin
								if (!wq_vld_q[qs]) wq_head_q[qs] <= cur_q;
								wq_tail_q[qs] <= cur_q;
								wq_vld_q[qs] <= 1'b1;
							end
						end
						CMD_WAKE: begin
							mode_q <= MODE_SHORT;
							if (!(q_ok && wq_vld_q[qs] && cnt_q != '0)) status_q <= ST_NO_WAKE;
							else if (resch_q) begin
								rq_head_q[cp] <= cur_q;
								if (!rq_vld_q[cp]) rq_tail_q[cp] <= cur_q;
								rq_vld_q[cp] <= 1'b1;
								mask_q[cp] <= 1'b1;
							end
						end
						default: status_q <= ST_OK;
					endcase
				end
				S_SCHED: begin
					if (dead_q != '0) used_q[SW'(dead_q - 1'b1)] <= 1'b0;
					dead_q <= (mode_q == MODE_DEAD) ? ({1'b0, cur_q} + 1'b1) : '0;
					rp_q <= top_p;
					if (mode_q == MODE_YIELD && !rp_lt_cp()) begin
						if (!rq_vld_q[cp]) rq_head_q[cp] <= cur_q;
						rq_tail_q[cp] <= cur_q;
						rq_vld_q[cp] <= 1'b1;
						mask_q[cp] <= 1'b1;
					end
				end
				S_POP_WB: begin
					cur_q <= rq_head_q[rp_q];
					if (rq_head_q[rp_q] == rq_tail_q[rp_q]) begin
						rq_vld_q[rp_q] <= 1'b0;
						mask_q[rp_q] <= 1'b0;
					end else begin
						rq_head_q[rp_q] <= link_rd_q;
					end
				end
				S_WAKE_WB: begin
					if (wq_head_q[qs] == wq_tail_q[qs]) wq_vld_q[qs] <= 1'b0;
					else wq_head_q[qs] <= link_rd_q;
					rq_head_q[wp] <= ws;
					if (!rq_vld_q[wp]) rq_tail_q[wp] <= ws;
					rq_vld_q[wp] <= 1'b1;
					mask_q[wp] <= 1'b1;
					cnt_q <= cnt_q - 1'b1;
				end
				S_OUT: begin
					if (out_load) begin
						out_q.switched <= cur_q != prev_q;
						out_q.prev_task <= 5'(prev_q);
						out_q.next_task <= 5'(cur_q);
						out_q.next_value <= (cur_q != prev_q && val_ok_q[cur_q]) ? val_rd_q : '0;
						out_q.new_handle <= handle_q;
						out_q.status <= status_q;
					end
				end
				default: rp_q <= rp_q;
			endcase
		end
	end

endmodule

// ===== bench/priority_task_scheduler_core_tb.sv =====
module priority_task_scheduler_core_tb;
	import pts_pkg::*;

	localparam int NQ = 48;   // run queues 0..31, wait queues 32..47
	localparam int WQ0 = 32;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_beat;
	logic out_valid;
	logic out_ready;
	out_beat_t out_beat;
	logic cfg_we;
	logic [4:0] cfg_data;

	priority_task_scheduler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_beat(in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat(out_beat),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	in_beat_t cmd_pending[$];
	out_beat_t sched_expected[$];
	int errors = 0;
	int cmds_sent = 0;
	int results_seen = 0;
	int switches_seen = 0;
	int wakes_done = 0;
	int stall_cycles = 0;
	bit calm = 0;

	// scheduler state mirror
	logic [4:0] main_prio;
	logic [4:0] cur_slot;
	logic [31:0] ready_bits;
	logic [4:0] q_head[NQ];
	logic [4:0] q_tail[NQ];
	bit q_busy[NQ];
	logic [4:0] link[32];
	logic [4:0] slot_prio[32];
	logic [31:0] slot_val[32];
	bit slot_taken[32];
	logic [5:0] dead_pend;
	logic [5:0] live_tasks;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void q_append(int q, logic [4:0] s);
		if (q_busy[q]) begin
			link[q_tail[q]] = s;
			q_tail[q] = s;
		end else begin
			q_head[q] = s;
			q_tail[q] = s;
			q_busy[q] = 1;
		end
	endfunction

	function automatic void q_prepend(int q, logic [4:0] s);
		if (q_busy[q]) begin
			link[s] = q_head[q];
			q_head[q] = s;
		end else begin
			q_head[q] = s;
			q_tail[q] = s;
			q_busy[q] = 1;
		end
	endfunction

	function automatic logic [4:0] q_take(int q);
		logic [4:0] s;
		s = q_head[q];
		if (q_head[q] == q_tail[q])
			q_busy[q] = 0;
		else
			q_head[q] = link[q_head[q]];
		return s;
	endfunction

	function automatic logic [4:0] highest_ready(logic [31:0] m);
		for (int p = 31; p >= 0; p--)
			if (m[p])
				return p[4:0];
		return 5'd0;
	endfunction

	function automatic void reschedule_cpu(mode_t mode);
		logic [31:0] m;
		logic [4:0] rp;
		logic [4:0] cp;
		m = ready_bits;
		if (dead_pend != 0) begin
			slot_taken[dead_pend - 1] = 0;
			dead_pend = '0;
		end
		rp = highest_ready(m);
		if (mode == MODE_YIELD) begin
			cp = slot_prio[cur_slot];
			if (rp < cp)
				return;
			q_append(cp, cur_slot);
			m[cp] = 1;
		end else if (mode == MODE_DEAD) begin
			dead_pend = cur_slot + 6'd1;
			live_tasks = live_tasks - 6'd1;
		end
		if (!q_busy[rp]) begin
			ready_bits = m;
			return;
		end
		cur_slot = q_take(rp);
		if (!q_busy[rp])
			m[rp] = 0;
		ready_bits = m;
	endfunction

	function automatic void model_reset();
		main_prio = MAIN_PRIO_RESET;
		for (int i = 0; i < NQ; i++)
			q_busy[i] = 0;
		for (int i = 0; i < 32; i++) begin
			link[i] = '0;
			slot_prio[i] = '0;
			slot_val[i] = '0;
			slot_taken[i] = 0;
		end
		slot_taken[IDLE_SLOT] = 1;
		slot_taken[MAIN_SLOT] = 1;
		slot_prio[IDLE_SLOT] = 5'(IDLE_PRIO);
		slot_prio[MAIN_SLOT] = main_prio;
		cur_slot = 5'(MAIN_SLOT);
		ready_bits = 32'd1 << IDLE_PRIO;
		q_append(IDLE_PRIO, 5'(IDLE_SLOT));
		dead_pend = '0;
		live_tasks = 6'd2;
	endfunction

	function automatic out_beat_t run_command(in_beat_t b);
		out_beat_t r;
		logic [4:0] prev;
		logic [4:0] s;
		logic [4:0] p;
		int cnt;
		int wq;
		int free_slot;
		prev = cur_slot;
		r = '0;
		wq = WQ0 + b.queue_index;
		case (b.command)
			CMD_CREATE: begin
				free_slot = -1;
				for (int i = 0; i < 32; i++)
					if (!slot_taken[i] && free_slot < 0)
						free_slot = i;
				if (free_slot < 0) begin
					r.status = ST_NO_SLOT;
				end else begin
					slot_taken[free_slot] = 1;
					slot_prio[free_slot] = b.task_prio;
					slot_val[free_slot] = b.item_value;
					q_append(b.task_prio, free_slot[4:0]);
					ready_bits[b.task_prio] = 1;
					live_tasks = live_tasks + 6'd1;
					r.new_handle = 6'(free_slot + 1);
				end
			end
			CMD_YIELD: reschedule_cpu(MODE_YIELD);
			CMD_EXIT: if (ready_bits != 0) reschedule_cpu(MODE_DEAD);
			CMD_BLOCK: begin
				if (ready_bits != 0) begin
					q_append(wq, cur_slot);
					reschedule_cpu(MODE_BLOCK);
				end
			end
			CMD_WAKE: begin
				if (!q_busy[wq] || b.wake_count == 0) begin
					r.status = ST_NO_WAKE;
				end else begin
					if (b.reschedule) begin
						p = slot_prio[cur_slot];
						q_prepend(p, cur_slot);
						ready_bits[p] = 1;
					end
					cnt = b.wake_count;
					do begin
						s = q_take(wq);
						slot_val[s] = b.item_value;
						q_prepend(slot_prio[s], s);
						ready_bits[slot_prio[s]] = 1;
						cnt--;
					end while (q_busy[wq] && cnt != 0);
					if (b.reschedule)
						reschedule_cpu(MODE_SHORT);
					wakes_done++;
				end
			end
			default: ;
		endcase
		r.switched = cur_slot != prev;
		r.prev_task = prev;
		r.next_task = cur_slot;
		r.next_value = r.switched ? slot_val[cur_slot] : 32'd0;
		return r;
	endfunction

	function automatic in_beat_t mk(logic [2:0] c, logic [4:0] p, logic [31:0] v,
		logic [3:0] q, logic [5:0] n, logic rs);
		in_beat_t b;
		b.command = c;
		b.task_prio = p;
		b.item_value = v;
		b.queue_index = q;
		b.wake_count = n;
		b.reschedule = rs;
		return b;
	endfunction

	function automatic in_beat_t random_cmd();
		in_beat_t b;
		int w;
		b.command = CMD_CREATE;
		b.task_prio = 5'($urandom_range(31));
		b.item_value = ($urandom_range(9) == 0) ? {32{$urandom_range(1) == 1}} : $urandom;
		b.queue_index = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
			4'($urandom_range(2));
		w = $urandom_range(9);
		b.wake_count = (w == 0) ? 6'd0 : (w == 1) ? 6'($urandom_range(63)) :
			6'($urandom_range(1, 4));
		b.reschedule = 1'($urandom_range(1));
		w = $urandom_range(99);
		if (w < 24)
			b.command = CMD_CREATE;
		else if (w < 44)
			b.command = CMD_YIELD;
		else if (w < 56)
			b.command = CMD_EXIT;
		else if (w < 74)
			b.command = CMD_BLOCK;
		else if (w < 97)
			b.command = CMD_WAKE;
		else
			b.command = 3'($urandom_range(5, 7));
		return b;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 0;
			out_ready <= 0;
		end else begin
			if (in_valid && in_ready) begin
				sched_expected.push_back(run_command(in_beat));
				cmds_sent++;
			end
			if (!in_valid || in_ready) begin
				if (cmd_pending.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
					in_beat <= cmd_pending.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
			out_ready <= calm || $urandom_range(99) >= 22;
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (sched_expected.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					e = sched_expected.pop_front();
					if (e.switched)
						switches_seen++;
					if (out_beat.switched !== e.switched) begin
						$error("switched: exp %0d got %0d", e.switched, out_beat.switched);
						errors++;
					end
					if (out_beat.prev_task !== e.prev_task) begin
						$error("prev_task: exp %0d got %0d", e.prev_task, out_beat.prev_task);
						errors++;
					end
					if (out_beat.next_task !== e.next_task) begin
						$error("next_task: exp %0d got %0d", e.next_task, out_beat.next_task);
						errors++;
					end
					if (out_beat.next_value !== e.next_value) begin
						$error("next_value: exp %h got %h", e.next_value, out_beat.next_value);
						errors++;
					end
					if (out_beat.new_handle !== e.new_handle) begin
						$error("new_handle: exp %0d got %0d", e.new_handle, out_beat.new_handle);
						errors++;
					end
					if (out_beat.status !== e.status) begin
						$error("status: exp %0d got %0d", e.status, out_beat.status);
						errors++;
					end
				end
			end
			if ((out_valid && out_ready) || (in_valid && in_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles > 20000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic drain();
		while (cmd_pending.size() > 0 || in_valid || sched_expected.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_main_prio(logic [4:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		main_prio = v;
		if (cur_slot == MAIN_SLOT)
			slot_prio[MAIN_SLOT] = v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		logic [4:0] prio_plan[8];
		prio_plan = '{5'd0, 5'd31, 5'd2, 5'd1, 5'd17, 5'd31, 5'd0, 5'd9};
		arst_n = 0;
		in_valid = 0;
		out_ready = 0;
		in_beat = '0;
		cfg_we = 0;
		cfg_data = '0;
		model_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed opening
		cmd_pending.push_back(mk(CMD_CREATE, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_CREATE, 5'd31, 32'hFFFF_FFFF, 4'd15, 6'd63, 1'b1));
		cmd_pending.push_back(mk(CMD_CREATE, 5'd2, 32'hA5A5_5A5A, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_WAKE, 5'd0, 32'h1234, 4'd0, 6'd1, 1'b1));
		cmd_pending.push_back(mk(CMD_YIELD, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_BLOCK, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_BLOCK, 5'd0, 32'h0, 4'd15, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_BLOCK, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_WAKE, 5'd0, 32'hDEAD_BEEF, 4'd0, 6'd0, 1'b1));
		cmd_pending.push_back(mk(CMD_WAKE, 5'd0, 32'hFFFF_FFFF, 4'd15, 6'd32, 1'b0));
		cmd_pending.push_back(mk(CMD_WAKE, 5'd0, 32'h0, 4'd0, 6'd63, 1'b1));
		cmd_pending.push_back(mk(CMD_YIELD, 5'd31, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_EXIT, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_EXIT, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(3'd5, 5'd31, 32'hFFFF_FFFF, 4'd15, 6'd63, 1'b1));
		cmd_pending.push_back(mk(3'd6, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(3'd7, 5'd1, 32'h1, 4'd1, 6'd1, 1'b1));
		cmd_pending.push_back(mk(CMD_WAKE, 5'd0, 32'h0, 4'd7, 6'd1, 1'b1));
		for (int i = 0; i < 6; i++)
			cmd_pending.push_back(mk(CMD_EXIT, 5'd0, 32'h0, 4'd0, 6'd0, 1'b0));
		cmd_pending.push_back(mk(CMD_CREATE, 5'd5, 32'h5555_5555, 4'd0, 6'd0, 1'b0));

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_main_prio(prio_plan[ph]);
			calm = (ph == 3);
			for (int i = 0; i < 235; i++)
				cmd_pending.push_back(random_cmd());
		end
		drain();

		$display("Ran %0d commands in 8 main-priority settings: %0d task switches, %0d wakes.",
			cmds_sent, switches_seen, wakes_done);
		if (errors == 0 && results_seen == cmds_sent)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
